[hw/rtl/crc32wpb_pkg.sv]
// Shared types, register indexes and the byte-absorb function of the
// word-per-byte CRC-32 block. No dependencies.
package crc32wpb_pkg;

	localparam int unsigned CrcWidth  = 32;
	localparam int unsigned ByteWidth = 8;

	localparam logic [CrcWidth-1:0] PolyReset = 32'h0000_0091;
	localparam logic [CrcWidth-1:0] InitReset = 32'hFFFF_FFFF;
	localparam logic [CrcWidth-1:0] CrcMsb    = 32'h8000_0000;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_POLY = 1'b0,
		REG_INIT = 1'b1
	} reg_idx_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [CrcWidth-1:0] poly;
		logic [CrcWidth-1:0] init;
	} cfg_t;

	// Absorb one byte, zero-extended to a 32-bit word, MSB first through
	// 32 shift steps. The data bit and the shifted-out bit combine into one
	// feedback bit, since XORing the polynomial twice cancels.
	function automatic logic [CrcWidth-1:0] crc_absorb_byte(
		input logic [CrcWidth-1:0]  crc_in,
		input logic [ByteWidth-1:0] data,
		input logic [CrcWidth-1:0]  poly
	);
		logic [CrcWidth-1:0] crc;
		logic [CrcWidth-1:0] word;
		logic                fb;
		crc  = crc_in;
		word = {{(CrcWidth-ByteWidth){1'b0}}, data};
		for (int i = 0; i < CrcWidth; i++) begin
			fb   = ((crc & CrcMsb) != '0) ^ word[CrcWidth-1-i];
			crc  = {crc[CrcWidth-2:0], 1'b0};
			crc  = fb ? (crc ^ poly) : crc;
		end
		return crc;
	endfunction

endpackage

[hw/rtl/crc32wpb_cfg.sv]
// Configuration registers (polynomial, initial value) of the CRC block.
// Depends on crc32wpb_pkg.
module crc32wpb_cfg
	import crc32wpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CrcWidth-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly <= PolyReset;
			cfg_q.init <= InitReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_POLY: cfg_q.poly <= cfg_wdata;
				REG_INIT: cfg_q.init <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/crc32wpb_core.sv]
// Running CRC state and the combinational byte absorb between the input
// stage and the result register. Depends on crc32wpb_pkg.
module crc32wpb_core
	import crc32wpb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 advance,
	input  logic [ByteWidth-1:0] data_s1,
	input  logic                 last_s1,
	output logic [CrcWidth-1:0]  crc_next
);

	logic [CrcWidth-1:0] crc_q;
	logic                at_start_q;
	logic [CrcWidth-1:0] crc_start;

	// Start each message from the initial value
	assign crc_start = at_start_q ? cfg.init : crc_q;
	assign crc_next  = crc_absorb_byte(crc_start, data_s1, cfg.poly);

	// Update running CRC when the byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= InitReset;
			at_start_q <= 1'b1;
		end else if (advance) begin
			crc_q      <= crc_next;
			at_start_q <= last_s1;
		end
	end

endmodule

[hw/rtl/crc32_word_per_byte.sv]
// Top level of the word-per-byte CRC-32: input stage, result register and
// handshake. Depends on crc32wpb_pkg, crc32wpb_cfg and crc32wpb_core.
//
// Usage:
//   Message bytes arrive on the s_ stream, one per transfer; s_tlast marks
//   the final byte of a message. Every byte yields one result on the m_
//   stream: the running CRC after that byte, with m_tlast set when it is the
//   finished CRC of the message (no final XOR). The next byte after a last
//   byte starts over from the initial value register.
//   A transferred byte passes the input stage, then the result register.
//   Throughput is one byte per cycle while the receiver takes results; the
//   32 shift steps of one byte settle in combinational logic between the
//   input stage and result register, closing the loop through the CRC state.
//   When the receiver stalls, the result register holds and the input stage
//   still takes one more byte; s_tready drops once both are full.
//   Reset clears both stages, sets the polynomial to 0x91 and the initial
//   value to 0xFFFFFFFF, and marks the next byte as a message start.
//   Configuration writes (index 0 polynomial, index 1 initial value) take
//   effect at once; the user makes them while no byte is in flight (unenforced).
module crc32_word_per_byte
	import crc32wpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CrcWidth-1:0] cfg_wdata,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] data_byte
	input  logic                s_tlast,   // last_byte
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // [31:0] running_crc
	output logic                m_tlast    // final_value
);

	cfg_t                 cfg;
	logic                 valid_s1;
	logic [ByteWidth-1:0] data_s1;
	logic                 last_s1;
	logic                 valid_s2;
	logic [CrcWidth-1:0]  crc_s2;
	logic                 last_s2;
	logic                 out_free;
	logic                 advance;
	logic                 in_xfer;
	logic [CrcWidth-1:0]  crc_next;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_xfer  = s_tvalid && s_tready;

	crc32wpb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	crc32wpb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.advance  (advance),
		.data_s1  (data_s1),
		.last_s1  (last_s1),
		.crc_next (crc_next)
	);

	// Input stage valid: fill on transfer, drain on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Result register valid: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			crc_s2  <= crc_next;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = crc_s2;
	assign m_tlast  = last_s2;

endmodule

[hw/rtl/crc32wpb_checker.sv]
// Port-level checker for crc32_word_per_byte and its bind statement.
// Depends only on the top level's ports.
module crc32wpb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// Empty result register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty result register");

	// A valid result follows every accepted byte
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after input transfer");

	// Drop valid only after a transfer
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without transfer");

endmodule

bind crc32_word_per_byte crc32wpb_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[bench/crc32_word_per_byte_check.sv]
// Checker for crc32_word_per_byte: follows configuration writes, predicts the
// running CRC of every input transfer and compares result transfers in order.
// Depends on crc32wpb_pkg.
module crc32_word_per_byte_check
	import crc32wpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CrcWidth-1:0] cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] data_byte
	input  logic                s_tlast,   // last_byte
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [31:0]         m_tdata,   // [31:0] running_crc
	input  logic                m_tlast,   // final_value
	output int                  failures,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CrcWidth-1:0] crc;
		logic                done;
	} crc_result_t;

	logic [CrcWidth-1:0] poly_reg;
	logic [CrcWidth-1:0] init_reg;
	logic [CrcWidth-1:0] crc_state;
	logic                msg_start;
	crc_result_t         crc_results[$];
	int                  fail_total = 0;

	// Shift one zero-extended byte through 32 steps, MSB first; the bit that
	// falls out and the data bit each fold the polynomial in on their own.
	function automatic logic [CrcWidth-1:0] crc_after_byte(
		input logic [CrcWidth-1:0] crc,
		input logic [7:0]          data,
		input logic [CrcWidth-1:0] poly
	);
		logic [CrcWidth-1:0] word;
		logic                shifted_out;
		logic                data_bit;
		word = {24'h0, data};
		for (int i = CrcWidth - 1; i >= 0; i--) begin
			shifted_out = crc[CrcWidth-1];
			data_bit    = word[i];
			crc         = crc << 1;
			if (shifted_out)
				crc ^= poly;
			if (data_bit)
				crc ^= poly;
		end
		return crc;
	endfunction

	// Track configuration, predict on input transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		crc_result_t want;
		if (!arst_n) begin
			poly_reg  = PolyReset;
			init_reg  = InitReset;
			crc_state = InitReset;
			msg_start = 1'b1;
			crc_results.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_POLY: poly_reg = cfg_wdata;
					REG_INIT: init_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (msg_start)
					crc_state = init_reg;
				crc_state = crc_after_byte(crc_state, s_tdata, poly_reg);
				crc_results.push_back('{crc: crc_state, done: s_tlast});
				msg_start = s_tlast;
			end
			if (m_tvalid && m_tready) begin
				if (crc_results.size() == 0) begin
					$error("unexpected result transfer: running_crc %h final_value %b",
						m_tdata, m_tlast);
					fail_total++;
				end else begin
					want = crc_results.pop_front();
					if (m_tdata !== want.crc) begin
						$error("running_crc: expected %h actual %h", want.crc, m_tdata);
						fail_total++;
					end
					if (m_tlast !== want.done) begin
						$error("final_value: expected %b actual %b", want.done, m_tlast);
						fail_total++;
					end
				end
			end
		end
		failures <= fail_total;
		pending  <= crc_results.size();
	end

endmodule

[bench/crc32_word_per_byte_test.sv]
// Top of the crc32_word_per_byte bench: clock, reset, configuration writes,
// byte stream and result backpressure. Depends on crc32wpb_pkg, the block and
// crc32_word_per_byte_check.
module crc32_word_per_byte_test
	import crc32wpb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ByteTarget  = 450;
	localparam int HoldCycles  = 150;
	localparam int CycleLimit  = 300000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [0:0]          cfg_index = 1'b0;
	logic [CrcWidth-1:0] cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = '0;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [31:0]         m_tdata;
	logic                m_tlast;

	int failures;
	int pending;
	int cycles        = 0;
	int sent          = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	bit tx_idle       = 1'b0;
	bit rx_idle       = 1'b0;

	crc32_word_per_byte uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	crc32_word_per_byte_check checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.failures (failures),
		.pending  (pending)
	);

	always #10ns clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one byte, after an optional gap, and hold it until the transfer
	task automatic send_byte(input logic [7:0] data, input logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// Drop valid and wait until every predicted result has been seen
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CrcWidth-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random register value, biased toward the extremes and known polynomials
	function automatic logic [CrcWidth-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return PolyReset;
			3: return 32'h04C1_1DB7;
			default: return $urandom;
		endcase
	endfunction

	// Random byte with extra weight on all-zeros and all-ones
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	// Send a run of messages; optionally leave the last one open
	task automatic send_messages(input int count, input bit close_last);
		int len;
		int left;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				send_byte(pick_byte(), (i == len - 1) && (close_last || left > len));
			left -= len;
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				gap = rx_idle ? $urandom_range(0, 12) : 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration, extreme bytes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		drain();

		// All-zero polynomial and start value
		cfg_write(REG_POLY, '0);
		cfg_write(REG_INIT, '0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		// All-ones polynomial and start value
		cfg_write(REG_POLY, '1);
		cfg_write(REG_INIT, '1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		drain();

		// Standard CRC-32 polynomial over the usual check string
		cfg_write(REG_POLY, 32'h04C1_1DB7);
		for (int i = 1; i <= 9; i++)
			send_byte(8'h30 + 8'(i), i == 9);
		drain();

		// Start value changed mid-message: current message keeps its value
		send_byte(8'h7F, 1'b0);
		drain();
		cfg_write(REG_INIT, 32'h0000_0000);
		send_byte(8'h01, 1'b1);
		drain();

		// Polynomial changed mid-message: applies from the next byte
		send_byte(8'h80, 1'b0);
		drain();
		cfg_write(REG_POLY, 32'h1EDC_6F41);
		send_byte(8'hFE, 1'b1);
		drain();

		// Start value changed between messages
		cfg_write(REG_INIT, 32'hA5A5_A5A5);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b1);

		// Random phases with fresh settings and idle patterns
		phase = 0;
		while (sent < ByteTarget) begin
			drain();
			if ($urandom_range(0, 1))
				cfg_write(REG_POLY, pick_word());
			if ($urandom_range(0, 1))
				cfg_write(REG_INIT, pick_word());
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if (phase == 3) begin
				// Back up the block behind a stalled receiver
				tx_idle = 1'b0;
				hold_requests++;
				send_messages(40, 1'b1);
			end else begin
				send_messages($urandom_range(20, 40), $urandom_range(0, 3) != 0);
			end
			phase++;
		end

		drain();
		repeat (6) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/crc32wpb_pkg.sv
hw/rtl/crc32wpb_cfg.sv
hw/rtl/crc32wpb_core.sv
hw/rtl/crc32_word_per_byte.sv
hw/rtl/crc32wpb_checker.sv
bench/crc32_word_per_byte_check.sv
bench/crc32_word_per_byte_test.sv
